// ===== rtl/crcwd_pkg.sv =====
// crcwd_pkg: shared types, constants and the crc-8 byte update for the word deframer
// no dependencies; imported by every module of the deframer
package crcwd_pkg;

    // crc-8, polynomial 0x31, init 0xff, msb first
    localparam logic [7:0]  CRC_INIT  = 8'hFF;
    localparam logic [7:0]  CRC_POLY  = 8'h31;
    localparam logic [7:0]  CRC_MSB   = 8'h80;
    localparam logic [15:0] BAD_WORD  = 16'hFFFF;

    // configuration register indexes and reset values
    localparam logic [7:0]  REG_WPF   = 8'd0;
    localparam logic [7:0]  REG_CHK   = 8'd1;
    localparam logic [7:0]  WPF_RESET = 8'd3;
    localparam logic        CHK_RESET = 1'b1;

    // which byte of the three-byte group comes next
    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_CRC
    } phase_t;

    typedef struct packed {
        logic [7:0] words_per_frame;
        logic       check_enable;
    } cfg_t;

    typedef struct packed {
        logic        ack_bit;
        logic        word_valid;
        logic [15:0] word_out;
        logic        crc_ok;
        logic [7:0]  word_index;
        logic        last_word;
    } result_t;

    // fold one byte into the running crc, eight shift steps
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_MSB) != 8'd0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc_checked_word_deframer_top.sv =====
// crc_checked_word_deframer_top: deframes high/low/crc byte groups into checked words
// depends on crcwd_pkg, crcwd_cfg, crcwd_deframe, crcwd_result_reg
// result: registered, valid in the cycle after its byte is accepted
// throughput: one byte per cycle unless a held result is stalled by res_ready, set by the single result register
// reset: phase and word counter clear, words_per_frame 3, check_enable 1
module crc_checked_word_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        ack_bit,
    output logic        word_valid,
    output logic [15:0] word_out,
    output logic        crc_ok,
    output logic [7:0]  word_index,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import crcwd_pkg::*;

    cfg_t    cfg;
    result_t res_next;
    result_t res;
    logic    rx_fire;

    assign rx_fire = rx_valid & rx_ready;

    crcwd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcwd_deframe u_deframe (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_fire  (rx_fire),
        .rx_byte  (rx_byte),
        .cfg      (cfg),
        .res_next (res_next)
    );

    crcwd_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .res_next  (res_next),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // unpack result word onto the field ports
    assign ack_bit    = res.ack_bit;
    assign word_valid = res.word_valid;
    assign word_out   = res.word_out;
    assign crc_ok     = res.crc_ok;
    assign word_index = res.word_index;
    assign last_word  = res.last_word;

endmodule

// ===== rtl/crcwd_cfg.sv =====
// crcwd_cfg: configuration registers (word count per transfer, crc check enable)
// depends on crcwd_pkg
module crcwd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output crcwd_pkg::cfg_t     cfg
);
    import crcwd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WPF: cfg_next.words_per_frame = cfg_data;
                REG_CHK: cfg_next.check_enable    = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.words_per_frame <= WPF_RESET;
            cfg_reg.check_enable    <= CHK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/crcwd_deframe.sv =====
// crcwd_deframe: byte phase tracking, data byte capture, running crc and result build
// depends on crcwd_pkg
module crcwd_deframe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_fire,
    input  logic [7:0]          rx_byte,
    input  crcwd_pkg::cfg_t     cfg,
    output crcwd_pkg::result_t  res_next
);
    import crcwd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] hi_reg;
    logic [7:0] hi_next;
    logic [7:0] lo_reg;
    logic [7:0] lo_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic [7:0] frame_len;
    logic       is_last;
    logic       crc_match;

    // a zero frame length acts as one word
    assign frame_len = (cfg.words_per_frame == 8'd0) ? 8'd1 : cfg.words_per_frame;
    assign is_last   = ({1'b0, cnt_reg} + 9'd1) >= {1'b0, frame_len};
    assign crc_match = (crc_reg == rx_byte);

    // next state: phase, captured bytes, running crc, word counter
    always_comb
    begin
        phase_next = phase_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        crc_next   = crc_reg;
        cnt_next   = cnt_reg;
        if (rx_fire)
        begin
            unique case (phase_reg)
                PH_LOW:
                begin
                    lo_next    = rx_byte;
                    crc_next   = crc8_feed(crc_reg, rx_byte);
                    phase_next = PH_CRC;
                end
                PH_CRC:
                begin
                    cnt_next   = is_last ? 8'd0 : cnt_reg + 8'd1;
                    phase_next = PH_HIGH;
                end
                default:
                begin
                    hi_next    = rx_byte;
                    crc_next   = crc8_feed(CRC_INIT, rx_byte);
                    phase_next = PH_LOW;
                end
            endcase
        end
    end

    // result for the byte at the input; data bytes give a plain ack
    always_comb
    begin
        res_next         = '0;
        res_next.ack_bit = 1'b1;
        unique case (phase_reg)
            PH_CRC:
            begin
                res_next.ack_bit    = ~is_last;
                res_next.word_valid = 1'b1;
                res_next.crc_ok     = crc_match;
                res_next.word_index = cnt_reg;
                res_next.last_word  = is_last;
                if (!crc_match && cfg.check_enable)
                begin
                    res_next.word_out = BAD_WORD;
                end
                else
                begin
                    res_next.word_out = {hi_reg, lo_reg};
                end
            end
            default:
            begin
                res_next.ack_bit = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HIGH;
            cnt_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // data registers need no reset
    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        crc_reg <= crc_next;
    end

    // a crc byte always ends the group
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && phase_reg == PH_CRC) |=> (phase_reg == PH_HIGH))
        else $error("phase did not return to high byte after crc byte");

    // high byte is captured and the low byte expected next
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && phase_reg == PH_HIGH) |=>
        (phase_reg == PH_LOW && hi_reg == $past(rx_byte)))
        else $error("high byte capture failed");

    // last word wraps the counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && phase_reg == PH_CRC && is_last) |=> (cnt_reg == 8'd0))
        else $error("word counter did not wrap after last word");

    // nack goes exactly with the last word mark
    assert property (@(posedge clk) disable iff (!rst_n)
        res_next.ack_bit != res_next.last_word)
        else $error("ack and last word mark disagree");

endmodule

// ===== rtl/crcwd_result_reg.sv =====
// crcwd_result_reg: output register holding one result word until taken
// depends on crcwd_pkg
module crcwd_result_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  crcwd_pkg::result_t  res_next,
    output logic                res_valid,
    input  logic                res_ready,
    output crcwd_pkg::result_t  res
);
    import crcwd_pkg::*;

    result_t res_reg;
    logic    res_valid_reg;
    logic    res_valid_next;
    logic    load;

    // take a byte whenever the slot is empty or being drained
    assign rx_ready = ~res_valid_reg | res_ready;
    assign load     = rx_valid & rx_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== dv/testbench.sv =====
// testbench for crc_checked_word_deframer_top: random and directed byte streams, checked
// against a scoreboard that deframes and crc-checks the same bytes on its own
// depends on crcwd_pkg and the deframer rtl
import crcwd_pkg::*;

// tracks the deframer state and keeps the results still owed by the block
class crc_word_tracker;
    logic [7:0] frame_len;
    logic       check_on;
    phase_t     phase;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
    logic [7:0] word_pos;
    result_t    pending[$];
    int         errors;

    function new();
        frame_len = WPF_RESET;
        check_on  = CHK_RESET;
        phase     = PH_HIGH;
        hi_byte   = 8'd0;
        lo_byte   = 8'd0;
        word_pos  = 8'd0;
        errors    = 0;
    endfunction

    // register writes; unknown indexes fall through
    function void write_reg(logic [7:0] idx, logic [7:0] data);
        if (idx == REG_WPF)
        begin
            frame_len = data;
        end
        else if (idx == REG_CHK)
        begin
            check_on = data[0];
        end
    endfunction

    // bitwise crc-8 update, msb first
    function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'd0);
        end
        return c;
    endfunction

    function logic [7:0] word_crc(logic [7:0] hi, logic [7:0] lo);
        return crc_step(crc_step(CRC_INIT, hi), lo);
    endfunction

    // one accepted byte gives exactly one result
    function void note_byte(logic [7:0] b);
        result_t    r;
        logic [7:0] len;
        logic       at_end;
        r = '0;
        r.ack_bit = 1'b1;
        case (phase)
            PH_LOW:
            begin
                lo_byte = b;
                phase   = PH_CRC;
            end
            PH_CRC:
            begin
                // a zero length behaves as one word per transfer
                len    = (frame_len == 8'd0) ? 8'd1 : frame_len;
                at_end = ({1'b0, word_pos} + 9'd1) >= {1'b0, len};
                r.word_valid = 1'b1;
                r.crc_ok     = (word_crc(hi_byte, lo_byte) == b);
                r.word_out   = (!r.crc_ok && check_on) ? BAD_WORD : {hi_byte, lo_byte};
                r.ack_bit    = !at_end;
                r.word_index = word_pos;
                r.last_word  = at_end;
                word_pos     = at_end ? 8'd0 : word_pos + 8'd1;
                phase        = PH_HIGH;
            end
            default:
            begin
                hi_byte = b;
                phase   = PH_LOW;
            end
        endcase
        pending.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
            end
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("result %0h arrived with nothing pending", got);
            end
            return;
        end
        want = pending.pop_front();
        compare("ack_bit", 16'(want.ack_bit), 16'(got.ack_bit));
        compare("word_valid", 16'(want.word_valid), 16'(got.word_valid));
        compare("word_out", want.word_out, got.word_out);
        compare("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
        compare("word_index", 16'(want.word_index), 16'(got.word_index));
        compare("last_word", 16'(want.last_word), 16'(got.last_word));
    endfunction

    // anything still owed at the end is a failure
    function void close_out();
        if (pending.size() != 0)
        begin
            $display("%0d results never arrived", pending.size());
            errors += pending.size();
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 600000;
    // indexes with no register behind them
    localparam logic [7:0] REG_SPARE_LO = 8'd2;
    localparam logic [7:0] REG_SPARE_HI = 8'hFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic        ack_bit;
    logic        word_valid;
    logic [15:0] word_out;
    logic        crc_ok;
    logic [7:0]  word_index;
    logic        last_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [7:0]  cfg_data = 8'd0;

    logic        send_idle = 1'b1;
    logic        recv_idle = 1'b1;
    int          cycle_count = 0;

    crc_word_tracker tracker = new();

    crc_checked_word_deframer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .ack_bit    (ack_bit),
        .word_valid (word_valid),
        .word_out   (word_out),
        .crc_ok     (crc_ok),
        .word_index (word_index),
        .last_word  (last_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 20 unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length(logic enabled);
        int r;
        if (!enabled)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // result side backpressure
    initial
    begin
        int stall;
        repeat (6) @(posedge clk);
        res_ready <= 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            stall = idle_length(recv_idle);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                res_ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            tracker.check_result({ack_bit, word_valid, word_out, crc_ok, word_index, last_word});
        end
    end

    // present one byte and hold it until taken; valid stays up when no gap follows
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
        begin
            @(posedge clk);
        end
        tracker.note_byte(b);
        gap = idle_length(send_idle);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain();
        rx_valid <= 1'b0;
        while (tracker.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // high, low and crc byte; pads first if the group is out of step
    task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input logic good);
        logic [7:0] crc;
        while (tracker.phase != PH_HIGH)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        crc = tracker.word_crc(hi, lo);
        if (!good)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(hi);
        send_byte(lo);
        send_byte(crc);
    endtask

    // random traffic, mostly well-formed words with a share of stray bytes
    task automatic run_traffic(input int n_bytes, input int noise_pct);
        int         sent;
        logic [7:0] hi;
        logic [7:0] lo;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end
            else
            begin
                hi = 8'($urandom_range(0, 255));
                lo = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0: hi = 8'h00;
                    1: lo = 8'hFF;
                    default: ;
                endcase
                send_word(hi, lo, $urandom_range(0, 99) < 75);
                sent += 3;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: three words per transfer, checking on
        send_word(8'h00, 8'h00, 1'b1);
        send_word(8'hFF, 8'hFF, 1'b1);
        send_word(8'hBE, 8'hEF, 1'b0);
        drain();

        // checking off via an even value, zero length, stray register indexes
        set_register(REG_CHK, 8'hFE);
        set_register(REG_WPF, 8'h00);
        set_register(REG_SPARE_LO, 8'h01);
        set_register(REG_SPARE_HI, 8'hFF);
        send_word(8'h12, 8'h34, 1'b0);
        drain();

        // shrink the transfer while the counter is already past the new end
        set_register(REG_WPF, 8'd5);
        set_register(REG_CHK, 8'h01);
        send_word(8'hA5, 8'h5A, 1'b1);
        send_word(8'h01, 8'h80, 1'b0);
        drain();
        set_register(REG_WPF, 8'd2);
        send_word(8'h7F, 8'h80, 1'b1);
        drain();

        // longest transfer, enough words to wrap the counter
        set_register(REG_WPF, 8'd255);
        set_register(REG_CHK, 8'($urandom_range(0, 255)));
        run_traffic(780, 0);
        drain();

        // shorter phases at mixed settings and idling
        for (int p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 5))
                0: set_register(REG_WPF, 8'd1);
                1: set_register(REG_WPF, 8'd255);
                2: set_register(REG_WPF, 8'd0);
                3: set_register(REG_WPF, 8'd2);
                default: set_register(REG_WPF, 8'($urandom_range(1, 12)));
            endcase
            set_register(REG_CHK, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
            begin
                set_register(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
            end
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            run_traffic(50, 10);
            drain();
        end

        tracker.close_out();
        if (tracker.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
